### design/i2crm_pkg.sv
package i2crm_pkg;

	// bus sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_ST_LOW     = 4'd1,
		PH_ST_HIGH    = 4'd2,
		PH_ST_FALL    = 4'd3,
		PH_TX_LOW     = 4'd4,
		PH_TX_HIGH    = 4'd5,
		PH_TXACK_LOW  = 4'd6,
		PH_TXACK_HIGH = 4'd7,
		PH_RX_LOW     = 4'd8,
		PH_RX_HIGH    = 4'd9,
		PH_RXACK_LOW  = 4'd10,
		PH_RXACK_HIGH = 4'd11,
		PH_SP_LOW     = 4'd12,
		PH_SP_HIGH    = 4'd13,
		PH_SP_RISE    = 4'd14
	} phase_t;

	// command modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_BURST = 2'd2;

	// byte stage within a transaction
	localparam logic [1:0] STG_DEV  = 2'd0;
	localparam logic [1:0] STG_REG  = 2'd1;
	localparam logic [1:0] STG_DATA = 2'd2;

	// register map (index taken from paddr[2])
	localparam logic REG_RETRY_LIMIT = 1'b0;

	localparam logic [3:0] RETRY_RESET = 4'd10;
	localparam logic [3:0] MAX_BURST   = 4'd8;
	localparam logic [3:0] BITS_BYTE   = 4'd8;
	localparam logic [7:0] READ_BIT    = 8'h01;

	// one tick beat on the input side
	typedef struct packed {
		logic       cmd_valid;
		logic [1:0] mode;
		logic [7:0] device_addr;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic [3:0] burst_count;
		logic       sda_in;
	} tick_t;

	// sequencer state
	typedef struct packed {
		phase_t     phase;
		logic [3:0] bit_count;
		logic [7:0] shift_byte;
		logic [3:0] tries_done;
		logic [3:0] bytes_left;
		logic [1:0] cmd_mode;
		logic [7:0] cmd_dev;
		logic [7:0] cmd_reg;
		logic [7:0] cmd_data;
		logic [1:0] stage;
		logic       retry_pending;
	} seq_state_t;

	// one result beat
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       byte_last;
		logic       done_res;
		logic       failed;
	} result_t;

endpackage

### design/i2crm_step.sv
module i2crm_step (
	input  i2crm_pkg::seq_state_t st,
	input  i2crm_pkg::tick_t      tick,
	input  logic [3:0]            retry_limit,
	output i2crm_pkg::seq_state_t nx,
	output i2crm_pkg::result_t    res
);
	import i2crm_pkg::*;

	logic [3:0] cnt;
	logic [3:0] lim;

	always_comb begin
		nx  = st;
		res = '0;
		res.busy_res = 1'b1;
		res.scl_out  = 1'b1;
		res.sda_out  = 1'b1;
		lim = (retry_limit == 4'd0) ? 4'd1 : retry_limit;
		cnt = tick.burst_count;
		if (cnt == 4'd0)
			cnt = 4'd1;
		if (cnt > MAX_BURST)
			cnt = MAX_BURST;

		// command taken only while idle, reserved mode ignored
		if (st.phase == PH_IDLE && tick.cmd_valid && tick.mode <= MODE_BURST) begin
			nx.cmd_mode      = tick.mode;
			nx.cmd_dev       = tick.device_addr;
			nx.cmd_reg       = tick.reg_addr;
			nx.cmd_data      = tick.write_data;
			nx.bytes_left    = (tick.mode == MODE_BURST) ? cnt : 4'd1;
			nx.tries_done    = 4'd0;
			nx.stage         = STG_DEV;
			nx.retry_pending = 1'b0;
			nx.phase         = PH_ST_HIGH;
		end

		unique case (nx.phase)
			PH_ST_LOW: begin
				res.scl_out = 1'b0;
				nx.phase    = PH_ST_HIGH;
			end
			PH_ST_HIGH: begin
				nx.phase = PH_ST_FALL;
			end
			PH_ST_FALL: begin
				res.sda_out   = 1'b0;
				nx.shift_byte = (nx.stage == STG_DEV) ? nx.cmd_dev : (nx.cmd_dev | READ_BIT);
				nx.bit_count  = 4'd0;
				nx.phase      = PH_TX_LOW;
			end
			PH_TX_LOW: begin
				res.scl_out = 1'b0;
				res.sda_out = nx.shift_byte[7];
				nx.phase    = PH_TX_HIGH;
			end
			PH_TX_HIGH: begin
				res.sda_out   = nx.shift_byte[7];
				nx.shift_byte = {nx.shift_byte[6:0], 1'b0};
				nx.bit_count  = nx.bit_count + 4'd1;
				nx.phase      = (nx.bit_count >= BITS_BYTE) ? PH_TXACK_LOW : PH_TX_LOW;
			end
			PH_TXACK_LOW: begin
				res.scl_out = 1'b0;
				nx.phase    = PH_TXACK_HIGH;
			end
			PH_TXACK_HIGH: begin
				if (nx.cmd_mode == MODE_WRITE) begin
					if (tick.sda_in) begin
						// NACK: stop, then retry decision
						nx.retry_pending = 1'b1;
						nx.phase         = PH_SP_LOW;
					end else if (nx.stage == STG_DEV) begin
						nx.stage      = STG_REG;
						nx.shift_byte = nx.cmd_reg;
						nx.bit_count  = 4'd0;
						nx.phase      = PH_TX_LOW;
					end else if (nx.stage == STG_REG) begin
						nx.stage      = STG_DATA;
						nx.shift_byte = nx.cmd_data;
						nx.bit_count  = 4'd0;
						nx.phase      = PH_TX_LOW;
					end else begin
						nx.phase = PH_SP_LOW;
					end
				end else begin
					// reads ignore slave NACK
					if (nx.stage == STG_DEV) begin
						nx.stage      = STG_REG;
						nx.shift_byte = nx.cmd_reg;
						nx.bit_count  = 4'd0;
						nx.phase      = PH_TX_LOW;
					end else if (nx.stage == STG_REG) begin
						nx.stage = STG_DATA;
						nx.phase = PH_ST_LOW;
					end else begin
						nx.bit_count  = 4'd0;
						nx.shift_byte = 8'd0;
						nx.phase      = PH_RX_LOW;
					end
				end
			end
			PH_RX_LOW: begin
				res.scl_out = 1'b0;
				nx.phase    = PH_RX_HIGH;
			end
			PH_RX_HIGH: begin
				nx.shift_byte = {nx.shift_byte[6:0], tick.sda_in};
				nx.bit_count  = nx.bit_count + 4'd1;
				if (nx.bit_count >= BITS_BYTE) begin
					res.byte_valid = 1'b1;
					res.read_byte  = nx.shift_byte;
					res.byte_last  = (nx.bytes_left <= 4'd1);
					nx.phase       = PH_RXACK_LOW;
				end else begin
					nx.phase = PH_RX_LOW;
				end
			end
			PH_RXACK_LOW: begin
				res.scl_out = 1'b0;
				res.sda_out = (nx.bytes_left <= 4'd1);
				nx.phase    = PH_RXACK_HIGH;
			end
			PH_RXACK_HIGH: begin
				res.sda_out = (nx.bytes_left <= 4'd1);
				if (nx.bytes_left <= 4'd1) begin
					nx.bytes_left = 4'd0;
					nx.phase      = PH_SP_LOW;
				end else begin
					nx.bytes_left = nx.bytes_left - 4'd1;
					nx.bit_count  = 4'd0;
					nx.shift_byte = 8'd0;
					nx.phase      = PH_RX_LOW;
				end
			end
			PH_SP_LOW: begin
				res.scl_out = 1'b0;
				res.sda_out = 1'b0;
				nx.phase    = PH_SP_HIGH;
			end
			PH_SP_HIGH: begin
				res.sda_out = 1'b0;
				nx.phase    = PH_SP_RISE;
			end
			PH_SP_RISE: begin
				if (nx.retry_pending) begin
					nx.tries_done = nx.tries_done + 4'd1;
					if (nx.tries_done < lim) begin
						nx.retry_pending = 1'b0;
						nx.stage         = STG_DEV;
						nx.phase         = PH_ST_HIGH;
					end else begin
						res.failed       = 1'b1;
						res.done_res     = 1'b1;
						nx.retry_pending = 1'b0;
						nx.phase         = PH_IDLE;
					end
				end else begin
					res.done_res = 1'b1;
					nx.phase     = PH_IDLE;
				end
			end
			default: begin
				nx.phase     = PH_IDLE;
				res.busy_res = 1'b0;
			end
		endcase
	end

endmodule

### design/i2c_register_master_unit.sv
// I2C register master advanced by phase ticks. Each slave-side beat is one
// tick of the external bus timer carrying the sampled SDA level and,
// optionally, a command (write, single read, burst read) that is taken only
// while idle. Each tick yields exactly one master-side beat with the SCL/SDA
// drive for that tick plus status (busy, received byte, done, failed). A tick
// is taken every clock cycle: the sequencer state advances through a single
// combinational step, and the result is loaded into an output register on
// the same edge as the state. The input keeps flowing while that register is
// emptied in the same cycle; it stalls only when a result is waiting and
// the downstream side is not ready. A register write is retried after a
// NACK up to retry_limit attempts (register 0, reset 10; zero acts as one).
// No clearing pass after reset.
module i2c_register_master_unit (
	input  logic        clk,
	input  logic        arst_n,
	// tick beats
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] cmd_valid, [8:1] device_addr, [16:9] reg_addr, [24:17] write_data,
	// [28:25] burst_count, [29] sda_in, [31:30] unused
	input  logic [31:0] s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]  s_axis_tuser,
	// result beats
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] scl_out, [1] sda_out, [2] busy_res, [3] byte_valid,
	// [11:4] read_byte, [12] done_res, [13] failed, [15:14] zero
	output logic [15:0] m_axis_tdata,
	output logic        m_axis_tlast,   // byte_last
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2crm_pkg::*;

	seq_state_t st_q;
	seq_state_t st_nx;
	tick_t      tick;
	result_t    res;
	result_t    res_q;
	logic       m_valid_q;
	logic [3:0] retry_limit_q;
	logic       in_beat;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RETRY_LIMIT) ? {28'd0, retry_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_RETRY_LIMIT) begin
			retry_limit_q <= pwdata[3:0];
		end
	end

	// unpack the tick beat
	assign tick.cmd_valid   = s_axis_tdata[0];
	assign tick.mode        = s_axis_tuser;
	assign tick.device_addr = s_axis_tdata[8:1];
	assign tick.reg_addr    = s_axis_tdata[16:9];
	assign tick.write_data  = s_axis_tdata[24:17];
	assign tick.burst_count = s_axis_tdata[28:25];
	assign tick.sda_in      = s_axis_tdata[29];

	// take a tick whenever the output register is empty or drains now
	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	i2crm_step u_step (
		.st          (st_q),
		.tick        (tick),
		.retry_limit (retry_limit_q),
		.nx          (st_nx),
		.res         (res)
	);

	// sequencer state; all-zero is idle with both lines released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_beat) begin
			st_q <= st_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (in_beat) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.failed, res_q.done_res, res_q.read_byte,
		res_q.byte_valid, res_q.busy_res, res_q.sda_out, res_q.scl_out};
	assign m_axis_tlast  = res_q.byte_last;

endmodule
